// ===== src/eul_pkg.sv =====
// shared types, constants and helpers for the euler angle to rotation matrix block
package eul_pkg;

    // sine datapath works on unsigned Q30 values that may reach exactly one
    typedef logic [30:0] q30_t;

    typedef struct packed {
        q30_t       z;
        q30_t       z2;
        q30_t       p;
        logic [1:0] quad;
    } sin_lane_t;

    typedef enum logic [2:0] {
        CELL_SQUARE = 3'b001,
        CELL_HORNER = 3'b010,
        CELL_FINAL  = 3'b100
    } cell_mode_t;

    localparam int LANES = 6;
    // lane order of the sine chain
    localparam int LN_SR = 0;
    localparam int LN_CR = 1;
    localparam int LN_SP = 2;
    localparam int LN_CP = 3;
    localparam int LN_SY = 4;
    localparam int LN_CY = 5;

    localparam q30_t ONE30 = 31'h4000_0000;
    localparam q30_t TA1   = 31'd1686629713;
    localparam q30_t TA3   = 31'd693598669;
    localparam q30_t TA5   = 31'd85569306;
    localparam q30_t TA7   = 31'd5026995;
    localparam q30_t TA9   = 31'd172272;
    localparam q30_t TA11  = 31'd3864;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd2;

    localparam int WIDE = 66;
    typedef logic signed [WIDE-1:0] wide_t;

    // round half up from 2*frac to frac fraction bits, then clamp to +-1
    function automatic logic signed [32:0] rnd_sat(input wide_t x, input int frac);
        wide_t r;
        wide_t one;
        begin
            one = wide_t'(1) <<< frac;
            r   = (x + (one >>> 1)) >>> frac;
            if (r > one)
            begin
                r = one;
            end
            else if (r < -one)
            begin
                r = -one;
            end
            return r[32:0];
        end
    endfunction

endpackage

// ===== src/eul_sin_cell.sv =====
// one step of the shared polynomial sine chain, six lanes wide
module eul_sin_cell #(
    parameter eul_pkg::cell_mode_t MODE = eul_pkg::CELL_HORNER,
    parameter eul_pkg::q30_t       COEF = eul_pkg::TA1
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  eul_pkg::sin_lane_t [eul_pkg::LANES-1:0]     in_lane,
    output logic                                        out_valid,
    output eul_pkg::sin_lane_t [eul_pkg::LANES-1:0]     out_lane
);

    logic                                    valid_reg;
    eul_pkg::sin_lane_t [eul_pkg::LANES-1:0] lane_reg;
    eul_pkg::sin_lane_t [eul_pkg::LANES-1:0] lane_next;

    always_comb
    begin
        logic [61:0] prod;
        for (int i = 0; i < eul_pkg::LANES; i++)
        begin
            lane_next[i] = in_lane[i];
            case (MODE)
                eul_pkg::CELL_SQUARE:
                begin
                    prod = 62'(in_lane[i].z) * 62'(in_lane[i].z);
                    lane_next[i].z2 = prod[60:30];
                    lane_next[i].p  = COEF;
                end
                eul_pkg::CELL_HORNER:
                begin
                    prod = 62'(in_lane[i].z2) * 62'(in_lane[i].p);
                    lane_next[i].p = COEF - prod[60:30];
                end
                eul_pkg::CELL_FINAL:
                begin
                    prod = 62'(in_lane[i].z) * 62'(in_lane[i].p);
                    // result lands in p, clamped to one
                    lane_next[i].p = (prod[60:30] > eul_pkg::ONE30) ? eul_pkg::ONE30
                                                                    : prod[60:30];
                end
                default:
                begin
                    prod = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

// ===== src/eul_row_out.sv =====
// holds one finished matrix pair and sends it as three row requests
module eul_row_out #(
    parameter int COEF_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load_valid,
    input  logic [2:0][2:0][COEF_BITS-1:0]      load_rot,
    input  logic [2:0][2:0][COEF_BITS-1:0]      load_rate,
    output logic                                load_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((6*COEF_BITS+7)/8)*8-1:0]    m_tdata,  // rot_col0..2, rate_col0..2
    output logic [1:0]                          m_tuser,  // row_index
    output logic                                m_tlast   // last_row
);

    logic                           full_reg;
    logic [1:0]                     row_reg;
    logic [2:0][2:0][COEF_BITS-1:0] rot_reg;
    logic [2:0][2:0][COEF_BITS-1:0] rate_reg;
    logic                           done;
    logic                           load;

    assign done       = m_tready && (row_reg == eul_pkg::ROW_LAST);
    assign load_ready = !full_reg || done;
    assign load       = load_valid && load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            row_reg  <= eul_pkg::ROW_FIRST;
        end
        else if (load)
        begin
            full_reg <= 1'b1;
            row_reg  <= eul_pkg::ROW_FIRST;
        end
        else if (full_reg && m_tready)
        begin
            full_reg <= !done;
            row_reg  <= done ? eul_pkg::ROW_FIRST : row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rot_reg  <= load_rot;
            rate_reg <= load_rate;
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int c = 0; c < 3; c++)
        begin
            m_tdata[c*COEF_BITS +: COEF_BITS]     = rot_reg[row_reg][c];
            m_tdata[(3+c)*COEF_BITS +: COEF_BITS] = rate_reg[row_reg][c];
        end
    end

    assign m_tvalid = full_reg;
    assign m_tuser  = row_reg;
    assign m_tlast  = (row_reg == eul_pkg::ROW_LAST);

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (row_reg != 2'd3))
        else $error("row counter out of range");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 2'd1))
        else $error("rows skipped or repeated");

    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (load && full_reg) |-> (m_tready && m_tlast))
        else $error("new matrix loaded over unsent rows");

endmodule

// ===== src/euler_to_rotation_matrices.sv =====
// top level: angle triple in, three rows of rotation and euler-rate matrices out
//
// Each accepted angle triple produces three result rows (row_index 0..2,
// tlast on row 2). The path from input request to the first row is a seven-cell
// sine chain (square, five polynomial steps, final product) working on six
// lanes at once, then rounding, the roll-pitch product, the matrix products,
// and the row buffer. The row buffer sets the rate: it takes a new matrix
// when empty or as its third row leaves, and the whole pipeline holds while
// a finished matrix waits for it.
module euler_to_rotation_matrices #(
    parameter int ANGLE_BITS = 16,
    parameter int COEF_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]   s_tdata,  // roll, pitch, yaw angle
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((6*COEF_BITS+7)/8)*8-1:0]    m_tdata,  // rot_col0..2, rate_col0..2
    output logic [1:0]                          m_tuser,  // row_index
    output logic                                m_tlast   // last_row
);

    localparam int F  = COEF_BITS - 2;
    localparam int SH = 30 - F;
    localparam int C  = COEF_BITS;
    localparam int NCELL = 7;

    typedef logic signed [C-1:0]   coef_t;
    typedef logic signed [2*C-1:0] prod_t;

    localparam eul_pkg::cell_mode_t CELL_MODE [NCELL] = '{
        eul_pkg::CELL_SQUARE, eul_pkg::CELL_HORNER, eul_pkg::CELL_HORNER,
        eul_pkg::CELL_HORNER, eul_pkg::CELL_HORNER, eul_pkg::CELL_HORNER,
        eul_pkg::CELL_FINAL
    };
    localparam eul_pkg::q30_t CELL_COEF [NCELL] = '{
        eul_pkg::TA11, eul_pkg::TA9, eul_pkg::TA7, eul_pkg::TA5,
        eul_pkg::TA3, eul_pkg::TA1, eul_pkg::TA1
    };

    logic adv;
    logic load_ready;

    // front: binary angles to folded sine arguments
    eul_pkg::sin_lane_t [eul_pkg::LANES-1:0] front_lane;
    always_comb
    begin
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < 3; i++)
        begin
            a = 32'(s_tdata[i*ANGLE_BITS +: ANGLE_BITS]) << (32 - ANGLE_BITS);
            for (int k = 0; k < 2; k++)
            begin
                // odd lanes take the cosine, a quarter turn ahead
                b = (k == 1) ? a + 32'h4000_0000 : a;
                front_lane[2*i+k].quad = b[31:30];
                front_lane[2*i+k].z    = b[30] ? eul_pkg::ONE30 - {1'b0, b[29:0]}
                                               : {1'b0, b[29:0]};
                front_lane[2*i+k].z2   = '0;
                front_lane[2*i+k].p    = '0;
            end
        end
    end

    logic                                    cell_valid [NCELL+1];
    eul_pkg::sin_lane_t [eul_pkg::LANES-1:0] cell_lane  [NCELL+1];

    assign cell_valid[0] = s_tvalid;
    assign cell_lane[0]  = front_lane;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            eul_sin_cell #(
                .MODE (CELL_MODE[g]),
                .COEF (CELL_COEF[g])
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (cell_valid[g]),
                .in_lane   (cell_lane[g]),
                .out_valid (cell_valid[g+1]),
                .out_lane  (cell_lane[g+1])
            );
        end
    endgenerate

    // rounding to coefficient format and quadrant sign
    coef_t trig_next [eul_pkg::LANES];
    always_comb
    begin
        logic [31:0] ext;
        logic [31:0] mag;
        for (int i = 0; i < eul_pkg::LANES; i++)
        begin
            ext = {1'b0, cell_lane[NCELL][i].p} + ((32'd1 << SH) >> 1);
            mag = ext >> SH;
            trig_next[i] = cell_lane[NCELL][i].quad[1] ? -coef_t'(mag[C-1:0])
                                                       : coef_t'(mag[C-1:0]);
        end
    end

    logic  vld_r_reg, vld_a_reg, vld_b_reg;
    coef_t trig_reg [eul_pkg::LANES];
    coef_t sr_a_reg, cr_a_reg, sp_a_reg, cp_a_reg, sy_a_reg, cy_a_reg;
    coef_t srsp_a_reg, crsp_a_reg;
    prod_t pr_b_reg [12];
    coef_t sp_b_reg, sr_b_reg, cr_b_reg;

    logic signed [2*C-1:0] srsp_p, crsp_p;
    assign srsp_p = trig_reg[eul_pkg::LN_SR] * trig_reg[eul_pkg::LN_SP];
    assign crsp_p = trig_reg[eul_pkg::LN_CR] * trig_reg[eul_pkg::LN_SP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_r_reg <= 1'b0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_r_reg <= cell_valid[NCELL];
            vld_a_reg <= vld_r_reg;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trig_reg   <= trig_next;
            sr_a_reg   <= trig_reg[eul_pkg::LN_SR];
            cr_a_reg   <= trig_reg[eul_pkg::LN_CR];
            sp_a_reg   <= trig_reg[eul_pkg::LN_SP];
            cp_a_reg   <= trig_reg[eul_pkg::LN_CP];
            sy_a_reg   <= trig_reg[eul_pkg::LN_SY];
            cy_a_reg   <= trig_reg[eul_pkg::LN_CY];
            srsp_a_reg <= coef_t'(eul_pkg::rnd_sat(eul_pkg::wide_t'(srsp_p), F));
            crsp_a_reg <= coef_t'(eul_pkg::rnd_sat(eul_pkg::wide_t'(crsp_p), F));
            pr_b_reg[0]  <= cp_a_reg * cy_a_reg;
            pr_b_reg[1]  <= cp_a_reg * sy_a_reg;
            pr_b_reg[2]  <= srsp_a_reg * cy_a_reg;
            pr_b_reg[3]  <= cr_a_reg * sy_a_reg;
            pr_b_reg[4]  <= srsp_a_reg * sy_a_reg;
            pr_b_reg[5]  <= cr_a_reg * cy_a_reg;
            pr_b_reg[6]  <= sr_a_reg * cp_a_reg;
            pr_b_reg[7]  <= crsp_a_reg * cy_a_reg;
            pr_b_reg[8]  <= sr_a_reg * sy_a_reg;
            pr_b_reg[9]  <= crsp_a_reg * sy_a_reg;
            pr_b_reg[10] <= sr_a_reg * cy_a_reg;
            pr_b_reg[11] <= cr_a_reg * cp_a_reg;
            sp_b_reg   <= sp_a_reg;
            sr_b_reg   <= sr_a_reg;
            cr_b_reg   <= cr_a_reg;
        end
    end

    // sums at double precision, one rounding each
    function automatic coef_t fin(input eul_pkg::wide_t x);
        return coef_t'(eul_pkg::rnd_sat(x, F));
    endfunction

    function automatic eul_pkg::wide_t wx(input prod_t x);
        return eul_pkg::wide_t'(x);
    endfunction

    logic [2:0][2:0][C-1:0] rot_c;
    logic [2:0][2:0][C-1:0] rate_c;
    coef_t                  one_c;
    coef_t                  nsp_c;
    coef_t                  nsr_c;

    always_comb
    begin
        one_c = coef_t'(1) <<< F;
        nsp_c = fin(-(eul_pkg::wide_t'(sp_b_reg) <<< F));
        nsr_c = fin(-(eul_pkg::wide_t'(sr_b_reg) <<< F));
        rot_c[0][0] = fin(wx(pr_b_reg[0]));
        rot_c[0][1] = fin(wx(pr_b_reg[1]));
        rot_c[0][2] = nsp_c;
        rot_c[1][0] = fin(wx(pr_b_reg[2]) - wx(pr_b_reg[3]));
        rot_c[1][1] = fin(wx(pr_b_reg[4]) + wx(pr_b_reg[5]));
        rot_c[1][2] = fin(wx(pr_b_reg[6]));
        rot_c[2][0] = fin(wx(pr_b_reg[7]) + wx(pr_b_reg[8]));
        rot_c[2][1] = fin(wx(pr_b_reg[9]) - wx(pr_b_reg[10]));
        rot_c[2][2] = fin(wx(pr_b_reg[11]));
        rate_c[0][0] = one_c;
        rate_c[0][1] = '0;
        rate_c[0][2] = nsp_c;
        rate_c[1][0] = '0;
        rate_c[1][1] = fin(eul_pkg::wide_t'(cr_b_reg) <<< F);
        rate_c[1][2] = rot_c[1][2];
        rate_c[2][0] = '0;
        rate_c[2][1] = nsr_c;
        rate_c[2][2] = rot_c[2][2];
    end

    assign adv      = !vld_b_reg || load_ready;
    assign s_tready = adv;

    eul_row_out #(
        .COEF_BITS (COEF_BITS)
    ) u_row_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (vld_b_reg),
        .load_rot   (rot_c),
        .load_rate  (rate_c),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    a_hold_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (vld_b_reg && m_tvalid))
        else $error("input held while pipeline can drain");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && vld_b_reg) |=> vld_b_reg)
        else $error("finished matrix dropped during hold");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == eul_pkg::ROW_LAST)))
        else $error("tlast does not match row index");

endmodule

// ===== test/tb_top.sv =====
// testbench for euler_to_rotation_matrices: random and directed angle triples, checked rows
`timescale 1ns / 1ps

class row_scoreboard;
    // one expected row: rot[0..2], rate[0..2], row index, last flag
    typedef struct {
        logic [1:0]  row;
        logic [15:0] rot [3];
        logic [15:0] rate [3];
        logic        last;
    } row_t;

    row_t        expected_rows [$];
    int          errors;
    int          rows_seen;
    int          triples_seen;

    function new();
        errors = 0;
        rows_seen = 0;
        triples_seen = 0;
    endfunction

    // polynomial sine on a q30 value in [0, 2^30]
    static function longint unsigned poly_sin(longint unsigned z);
        longint unsigned z2;
        longint unsigned p;
        longint unsigned s;
        z2 = (z * z) >> 30;
        p = 3864;
        p = 172272 - ((z2 * p) >> 30);
        p = 5026995 - ((z2 * p) >> 30);
        p = 85569306 - ((z2 * p) >> 30);
        p = 693598669 - ((z2 * p) >> 30);
        p = 1686629713 - ((z2 * p) >> 30);
        s = (z * p) >> 30;
        if (s > 64'h4000_0000)
            s = 64'h4000_0000;
        return s;
    endfunction

    static function longint binang_sin(logic [31:0] a);
        longint unsigned r;
        longint unsigned z;
        longint m;
        r = a[29:0];
        z = a[30] ? (64'h4000_0000 - r) : r;
        m = longint'((poly_sin(z) + 64'd32768) >> 16);
        return a[31] ? -m : m;
    endfunction

    // round a q2.28 product to q1.14, floor(x + 1/2)
    static function longint round_q14(longint x);
        return (x + 8192) >>> 14;
    endfunction

    static function longint clamp_one(longint v);
        if (v > 16384)
            return 16384;
        if (v < -16384)
            return -16384;
        return v;
    endfunction

    function void note_triple(logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw);
        logic [31:0] ar;
        logic [31:0] ap;
        logic [31:0] ay;
        longint sr, cr, sp, cp, sy, cy, srsp, crsp;
        longint rot [3][3];
        longint rate [3][3];
        row_t r;
        ar = {roll, 16'h0};
        ap = {pitch, 16'h0};
        ay = {yaw, 16'h0};
        sr = binang_sin(ar);
        cr = binang_sin(ar + 32'h4000_0000);
        sp = binang_sin(ap);
        cp = binang_sin(ap + 32'h4000_0000);
        sy = binang_sin(ay);
        cy = binang_sin(ay + 32'h4000_0000);
        srsp = clamp_one(round_q14(sr * sp));
        crsp = clamp_one(round_q14(cr * sp));
        rot[0][0] = round_q14(cp * cy);
        rot[0][1] = round_q14(cp * sy);
        rot[0][2] = -sp;
        rot[1][0] = round_q14(srsp * cy - cr * sy);
        rot[1][1] = round_q14(srsp * sy + cr * cy);
        rot[1][2] = round_q14(sr * cp);
        rot[2][0] = round_q14(crsp * cy + sr * sy);
        rot[2][1] = round_q14(crsp * sy - sr * cy);
        rot[2][2] = round_q14(cr * cp);
        rate[0][0] = 16384;
        rate[0][1] = 0;
        rate[0][2] = -sp;
        rate[1][0] = 0;
        rate[1][1] = cr;
        rate[1][2] = rot[1][2];
        rate[2][0] = 0;
        rate[2][1] = -sr;
        rate[2][2] = rot[2][2];
        for (int k = 0; k < 3; k++)
        begin
            r.row = k[1:0];
            for (int j = 0; j < 3; j++)
            begin
                r.rot[j] = 16'(clamp_one(rot[k][j]));
                r.rate[j] = 16'(clamp_one(rate[k][j]));
            end
            r.last = (k == 2);
            expected_rows.push_back(r);
        end
        triples_seen++;
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        if (errors <= 30)
            $display("mismatch row %0d %s: got %h expected %h", rows_seen, what, got, want);
    endtask

    task check_row(logic [95:0] data, logic [1:0] row, logic last);
        row_t e;
        if (expected_rows.size() == 0)
        begin
            report("row with no triple pending", 16'(row), 16'd0);
            rows_seen++;
            return;
        end
        e = expected_rows.pop_front();
        if (row !== e.row)
            report("row_index", 16'(row), 16'(e.row));
        if (last !== e.last)
            report("last_row", 16'(last), 16'(e.last));
        for (int j = 0; j < 3; j++)
        begin
            if (data[16*j +: 16] !== e.rot[j])
                report($sformatf("rot_col%0d", j), data[16*j +: 16], e.rot[j]);
            if (data[48 + 16*j +: 16] !== e.rate[j])
                report($sformatf("rate_col%0d", j), data[48 + 16*j +: 16], e.rate[j]);
        end
        rows_seen++;
    endtask
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    row_scoreboard rows_sb;
    int          cycle_count;
    bit          hold_sink;
    bit          long_stall;

    localparam int CYCLE_LIMIT = 200000;

    euler_to_rotation_matrices u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        rows_sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        hold_sink = 1'b0;
        long_stall = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // sample handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                rows_sb.note_triple(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
            if (m_tvalid && m_tready)
                rows_sb.check_row(m_tdata, m_tuser, m_tlast);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[euler_to_rotation_matrices] ERROR");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
    end

    // receiver: random ready gaps, one long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_stall)
            begin
                m_tready = 1'b0;
                repeat (60) @(negedge clk);
                long_stall = 1'b0;
            end
            if (hold_sink)
                gap = 0;
            else
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
        end
    end

    task automatic send_triple(input logic [15:0] roll, input logic [15:0] pitch,
                               input logic [15:0] yaw, input int gap);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {yaw, pitch, roll};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(($urandom_range(0, 7)) << 13);
            3: return 16'(($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 2)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic drain();
        s_tvalid = 1'b0;
        while (rows_sb.expected_rows.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [15:0] edge_angles [12];
        int gap;
        edge_angles = '{16'h0000, 16'h8000, 16'h7FFF, 16'h8001, 16'h4000, 16'hC000,
                        16'h2000, 16'hE000, 16'h0001, 16'hFFFF, 16'h3FFF, 16'h4001};
        @(posedge rst_n);
        @(negedge clk);
        // extremes, quadrant boundaries and gimbal-lock pitch
        for (int i = 0; i < 12; i++)
            send_triple(edge_angles[i], edge_angles[(i + 4) % 12], edge_angles[(i + 7) % 12],
                        i % 3);
        send_triple(16'h5555, 16'h4000, 16'hAAAA, 0);
        send_triple(16'hAAAA, 16'hC000, 16'h5555, 0);
        // sender pauses until every row is back
        drain();
        // receiver holds off while sender keeps offering
        long_stall = 1'b1;
        for (int i = 0; i < 20; i++)
            send_triple(16'($urandom), 16'($urandom), 16'($urandom), 0);
        for (int i = 0; i < 320; i++)
        begin
            if (i >= 100 && i < 140)
            begin
                hold_sink = 1'b1;
                gap = 0;
            end
            else
            begin
                hold_sink = 1'b0;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
            send_triple(pick_angle(), pick_angle(), pick_angle(), gap);
            if (i == 200)
                drain();
        end
        hold_sink = 1'b0;
        s_tvalid = 1'b0;
        while (rows_sb.expected_rows.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        $display("covered %0d angle triples and %0d result rows, with edge angles, pauses",
                 rows_sb.triples_seen, rows_sb.rows_seen);
        $display("and a long output stall that backed up the input");
        if (rows_sb.errors == 0)
            $display("[euler_to_rotation_matrices] OK");
        else
            $display("[euler_to_rotation_matrices] ERROR");
        $finish;
    end
endmodule
